### rtl/sewb_pkg.sv
// Package: constants, storage entry types, controller states and command/status structs.
`default_nettype none
package sewb_pkg;
    localparam int NODES     = 1024;
    localparam int MAX_EDGES = 1024;
    localparam int NODE_W    = $clog2(NODES);
    localparam int EDGE_AW   = $clog2(MAX_EDGES);
    localparam int CNT_W     = EDGE_AW + 1;
    localparam int SIZE_W    = NODE_W + 1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [NODE_W-1:0] parent;
        logic [SIZE_W-1:0] size;
        logic              par;
    } t_node_ent;

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] node;
        logic              old_par;
        logic              old_flag;
    } t_undo_ent;

    typedef struct packed {
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        logic              etype;
    } t_edge;

    typedef enum logic [1:0] {
        RM_FWD,
        RM_LIST0,
        RM_LIST1
    } t_rmode;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISP,
        S_P0,
        S_FA,
        S_FB,
        S_MG,
        S_MG2,
        S_PL0,
        S_PL1,
        S_U2,
        S_U3,
        S_U4,
        S_PLC,
        S_RNX,
        S_RR,
        S_RL,
        S_FN0,
        S_FN1,
        S_OUT
    } t_state;

    typedef struct packed {
        t_state op;
        logic   in_acc;
        logic   out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic req_pop;
        logic empty;
        logic full;
        logic is_root;
        logic u_valid;
        logic loop_more;
        logic rep_left;
        logic mode_l0;
        logic out_free;
    } t_stat;
endpackage
`default_nettype wire

### rtl/sewb_if.sv
// Interfaces: request and result channels with valid/ready handshake.
`default_nettype none
interface sewb_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [9:0]  node_a;
    logic [9:0]  node_b;
    modport source (output valid, req_type, node_a, node_b, input ready);
    modport sink   (input valid, req_type, node_a, node_b, output ready);
endinterface

interface sewb_res_if;
    logic        valid;
    logic        ready;
    logic        bipartite;
    logic [1:0]  status;
    logic [10:0] edge_count;
    modport source (output valid, bipartite, status, edge_count, input ready);
    modport sink   (input valid, bipartite, status, edge_count, output ready);
endinterface
`default_nettype wire

### rtl/sewb_ctrl.sv
// Controller: sequencing state machine for push, pop, find, undo and replay.
`default_nettype none
module sewb_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire sewb_pkg::t_stat i_stat,
    output sewb_pkg::t_cmd      o_cmd
);
    import sewb_pkg::*;

    t_state r_state, n_state;
    logic   r_ret_rep, n_ret_rep;
    logic   r_uret_fin, n_uret_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_ret_rep  <= 1'b0;
            r_uret_fin <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ret_rep  <= n_ret_rep;
            r_uret_fin <= n_uret_fin;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_ret_rep      = r_ret_rep;
        n_uret_fin     = r_uret_fin;
        o_ready        = 1'b0;
        o_cmd.op       = r_state;
        o_cmd.in_acc   = 1'b0;
        o_cmd.out_load = 1'b0;
        case (r_state)
            S_CLEAR: if (i_stat.clr_last) n_state = S_IDLE;
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.in_acc = 1'b1;
                    n_state      = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.req_pop) begin
                    n_state = i_stat.empty ? S_OUT : S_PL0;
                end else if (i_stat.full) begin
                    n_state = S_OUT;
                end else begin
                    n_ret_rep = 1'b0;
                    n_state   = S_P0;
                end
            end
            S_P0:  n_state = S_FA;
            S_FA:  if (i_stat.is_root) n_state = S_FB;
            S_FB:  if (i_stat.is_root) n_state = S_MG;
            S_MG:  n_state = S_MG2;
            S_MG2: n_state = r_ret_rep ? S_RNX : S_OUT;
            S_PL0: n_state = S_PL1;
            S_PL1: begin
                n_uret_fin = 1'b0;
                n_state    = i_stat.u_valid ? S_U2 : S_PLC;
            end
            S_U2:  n_state = S_U3;
            S_U3:  n_state = S_U4;
            S_U4:  n_state = r_uret_fin ? S_OUT : S_PLC;
            S_PLC: n_state = i_stat.loop_more ? S_PL0 : S_RNX;
            S_RNX: begin
                if (i_stat.rep_left)     n_state = S_RR;
                else if (i_stat.mode_l0) n_state = S_RNX;
                else                     n_state = S_FN0;
            end
            S_RR:  n_state = S_RL;
            S_RL: begin
                n_ret_rep = 1'b1;
                n_state   = S_P0;
            end
            S_FN0: n_state = S_FN1;
            S_FN1: begin
                n_uret_fin = 1'b1;
                n_state    = i_stat.u_valid ? S_U2 : S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end
endmodule
`default_nettype wire

### rtl/sewb_dp.sv
// Datapath: node, undo, edge and scratch memories, find walk, merge and rollback logic.
`default_nettype none
module sewb_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sewb_pkg::t_cmd       i_cmd,
    output sewb_pkg::t_stat           o_stat,
    input  wire logic                 i_req_type,
    input  wire logic [9:0]           i_node_a,
    input  wire logic [9:0]           i_node_b,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_bipartite,
    output logic [1:0]                o_status,
    output logic [10:0]               o_edge_count
);
    import sewb_pkg::*;

    t_node_ent node_mem [NODES];
    t_undo_ent undo_mem [MAX_EDGES];
    t_edge     stack_mem [MAX_EDGES];
    t_edge     scr_mem [MAX_EDGES];

    t_node_ent r_nrd;
    t_undo_ent r_urd;
    t_edge     r_srd;
    t_edge     r_crd;

    logic [NODE_W-1:0]  r_clr;
    logic [CNT_W-1:0]   r_depth, r_n0, r_n1, r_i;
    logic               r_flag, r_pop;
    logic [1:0]         r_st;
    logic [NODE_W-1:0]  r_ea, r_eb, r_u, r_ra, r_rb, r_y, r_pp;
    logic               r_etype, r_p, r_pa, r_pb, r_para, r_parb, r_pary, r_same, r_uold;
    logic [SIZE_W-1:0]  r_sza, r_szb, r_sum, r_szu;
    t_rmode             r_mode;
    logic               r_ov;
    logic               r_ob;
    logic [1:0]         r_os;
    logic [CNT_W-1:0]   r_oc;

    logic [NODE_W-1:0]  w_naddr, w_nwaddr;
    t_node_ent          w_nwdata;
    logic               w_nwe;
    logic [EDGE_AW-1:0] w_dm1, w_ridx, w_sidx;
    logic [CNT_W-1:0]   w_dm1_full, w_im1, w_b1;
    logic               w_root, w_z, w_same, w_swap, w_parx, w_pary;
    logic [NODE_W-1:0]  w_x, w_yy;
    logic [SIZE_W-1:0]  w_sx, w_sy;

    assign w_root     = (r_nrd.parent == r_u);
    assign w_dm1_full = r_depth - CNT_W'(1);
    assign w_dm1      = w_dm1_full[EDGE_AW-1:0];
    assign w_im1      = r_i - CNT_W'(1);
    assign w_b1       = CNT_W'(MAX_EDGES) - r_i;
    assign w_sidx     = EDGE_AW'(MAX_EDGES - 1) - r_n1[EDGE_AW-1:0];
    assign w_z        = r_pa ^ r_pb ^ 1'b1;
    assign w_same     = (r_ra == r_rb);
    assign w_swap     = (r_sza > r_szb);
    assign w_x        = w_swap ? r_rb : r_ra;
    assign w_yy       = w_swap ? r_ra : r_rb;
    assign w_sx       = w_swap ? r_szb : r_sza;
    assign w_sy       = w_swap ? r_sza : r_szb;
    assign w_parx     = w_swap ? r_parb : r_para;
    assign w_pary     = w_swap ? r_para : r_parb;

    always_comb begin
        case (r_mode)
            RM_FWD:   w_ridx = r_i[EDGE_AW-1:0];
            RM_LIST0: w_ridx = w_im1[EDGE_AW-1:0];
            default:  w_ridx = w_b1[EDGE_AW-1:0];
        endcase
    end

    always_comb begin
        case (i_cmd.op)
            S_P0:         w_naddr = r_ea;
            S_FA:         w_naddr = w_root ? r_eb : r_nrd.parent;
            S_FB:         w_naddr = r_nrd.parent;
            S_PL1, S_FN1: w_naddr = r_urd.node;
            S_U2:         w_naddr = r_nrd.parent;
            default:      w_naddr = r_u;
        endcase
    end

    always_comb begin
        w_nwe    = 1'b0;
        w_nwaddr = r_u;
        w_nwdata = r_nrd;
        case (i_cmd.op)
            S_CLEAR: begin
                w_nwe    = 1'b1;
                w_nwaddr = r_clr;
                w_nwdata = '{parent: r_clr, size: SIZE_W'(1), par: 1'b0};
            end
            S_MG: begin
                w_nwe    = !w_same;
                w_nwaddr = w_x;
                w_nwdata = '{parent: w_yy, size: w_sx, par: w_z};
            end
            S_MG2: begin
                w_nwe    = !r_same;
                w_nwaddr = r_y;
                w_nwdata = '{parent: r_y, size: r_sum, par: r_pary};
            end
            S_U3: begin
                w_nwe    = 1'b1;
                w_nwaddr = r_pp;
                w_nwdata = '{parent: r_nrd.parent, size: r_nrd.size - r_szu, par: r_nrd.par};
            end
            S_U4: begin
                w_nwe    = 1'b1;
                w_nwaddr = r_u;
                w_nwdata = '{parent: r_u, size: r_szu, par: r_uold};
            end
            default: w_nwe = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_nrd <= node_mem[w_naddr];
        if (w_nwe) node_mem[w_nwaddr] <= w_nwdata;
    end

    always_ff @(posedge i_clk) begin
        r_urd <= undo_mem[w_dm1];
        r_srd <= stack_mem[w_dm1];
        r_crd <= scr_mem[w_ridx];
        if (i_cmd.op == S_MG) begin
            undo_mem[r_depth[EDGE_AW-1:0]] <= w_same
                ? '{valid: 1'b0, node: '0, old_par: 1'b0, old_flag: r_flag}
                : '{valid: 1'b1, node: w_x, old_par: w_parx, old_flag: r_flag};
            stack_mem[r_depth[EDGE_AW-1:0]] <= '{a: r_ea, b: r_eb, etype: r_etype};
        end
        if (i_cmd.op == S_PL1) begin
            if (r_srd.etype) scr_mem[w_sidx] <= r_srd;
            else             scr_mem[r_n0[EDGE_AW-1:0]] <= r_srd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_depth <= '0;
            r_flag  <= 1'b1;
            r_ov    <= 1'b0;
            r_mode  <= RM_FWD;
        end else begin
            if (i_cmd.out_load)        r_ov <= 1'b1;
            else if (r_ov && i_ready)  r_ov <= 1'b0;
            case (i_cmd.op)
                S_CLEAR: r_clr <= r_clr + NODE_W'(1);
                S_MG:    if (w_same && w_z) r_flag <= 1'b0;
                S_MG2:   r_depth <= r_depth + CNT_W'(1);
                S_PL0, S_FN0: r_depth <= w_dm1_full;
                S_PL1, S_FN1: r_flag <= r_urd.old_flag;
                S_PLC: begin
                    if (r_n1 == '0) r_mode <= RM_FWD;
                    else            r_mode <= RM_LIST0;
                end
                S_RNX: if (!o_stat.rep_left && r_mode == RM_LIST0) r_mode <= RM_LIST1;
                default: r_clr <= r_clr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_acc) begin
            r_pop   <= i_req_type;
            r_ea    <= i_node_a;
            r_eb    <= i_node_b;
            r_etype <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_ob <= r_flag;
            r_os <= r_st;
            r_oc <= r_depth;
        end
        case (i_cmd.op)
            S_DISP: begin
                r_n0 <= '0;
                r_n1 <= '0;
                if (r_pop && r_depth == '0)       r_st <= ST_EMPTY;
                else if (!r_pop && r_depth[EDGE_AW]) r_st <= ST_FULL;
                else                              r_st <= ST_DONE;
            end
            S_P0: begin
                r_u <= r_ea;
                r_p <= 1'b0;
            end
            S_FA: begin
                if (w_root) begin
                    r_ra   <= r_u;
                    r_pa   <= r_p;
                    r_sza  <= r_nrd.size;
                    r_para <= r_nrd.par;
                    r_u    <= r_eb;
                    r_p    <= 1'b0;
                end else begin
                    r_u <= r_nrd.parent;
                    r_p <= r_p ^ r_nrd.par;
                end
            end
            S_FB: begin
                if (w_root) begin
                    r_rb   <= r_u;
                    r_pb   <= r_p;
                    r_szb  <= r_nrd.size;
                    r_parb <= r_nrd.par;
                end else begin
                    r_u <= r_nrd.parent;
                    r_p <= r_p ^ r_nrd.par;
                end
            end
            S_MG: begin
                r_same <= w_same;
                r_y    <= w_yy;
                r_sum  <= w_sx + w_sy;
                r_pary <= w_pary;
            end
            S_PL1, S_FN1: begin
                r_u    <= r_urd.node;
                r_uold <= r_urd.old_par;
                if (i_cmd.op == S_PL1) begin
                    if (r_srd.etype) r_n1 <= r_n1 + CNT_W'(1);
                    else             r_n0 <= r_n0 + CNT_W'(1);
                end
            end
            S_U2: begin
                r_szu <= r_nrd.size;
                r_pp  <= r_nrd.parent;
            end
            S_PLC: r_i <= (r_n1 == '0) ? '0 : r_n0;
            S_RNX: if (!o_stat.rep_left && r_mode == RM_LIST0) r_i <= r_n1;
            S_RR:  r_i <= (r_mode == RM_FWD) ? r_i + CNT_W'(1) : w_im1;
            S_RL: begin
                r_ea    <= r_crd.a;
                r_eb    <= r_crd.b;
                r_etype <= (r_mode == RM_FWD) ? 1'b1 : r_crd.etype;
            end
            default: r_p <= r_p;
        endcase
    end

    always_comb begin
        o_stat.clr_last  = &r_clr;
        o_stat.req_pop   = r_pop;
        o_stat.empty     = (r_depth == '0);
        o_stat.full      = r_depth[EDGE_AW];
        o_stat.is_root   = w_root;
        o_stat.u_valid   = r_urd.valid;
        o_stat.loop_more = (r_n1 < r_n0) && (r_depth != '0);
        o_stat.rep_left  = (r_mode == RM_FWD) ? (r_i < r_n0) : (r_i != '0);
        o_stat.mode_l0   = (r_mode == RM_LIST0);
        o_stat.out_free  = !r_ov || i_ready;
    end

    assign o_valid      = r_ov;
    assign o_bipartite  = r_ob;
    assign o_status     = r_os;
    assign o_edge_count = r_oc;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CNT_W'(MAX_EDGES))
        else $error("edge count beyond window size");
    a_merge_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == S_MG2 && !r_same) |-> r_sum <= SIZE_W'(NODES))
        else $error("merged set larger than node count");
    a_lists_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == S_PLC) |-> ({1'b0, r_n0} + {1'b0, r_n1}) <= (CNT_W + 1)'(MAX_EDGES))
        else $error("reorder lists overflow scratch");
endmodule
`default_nettype wire

### rtl/sliding_edge_window_bipartite_check.sv
// Top level: sliding edge window bipartite check, controller plus datapath.
// Push: DISP, P0, find walks FA and FB along each end node's parent chain, MG, MG2, then OUT.
// Pop: PL0, PL1, PLC per rolled-back entry (U2-U4 too if it undoes a merge); RNX, RR, RL,
//   push states per replayed edge; FN0, FN1 (U2-U4) drop oldest; amortised log run.
// One request at a time; a flagged request goes from DISP straight to OUT; ready returns
//   in the cycle after the result is loaded. Reset: node table swept to singleton roots.
`default_nettype none
module sliding_edge_window_bipartite_check (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sewb_req_if.sink  i_req,
    sewb_res_if.source o_res
);
    import sewb_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    sewb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    sewb_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_req_type   (i_req.req_type),
        .i_node_a     (i_req.node_a),
        .i_node_b     (i_req.node_b),
        .o_valid      (o_res.valid),
        .i_ready      (o_res.ready),
        .o_bipartite  (o_res.bipartite),
        .o_status     (o_res.status),
        .o_edge_count (o_res.edge_count)
    );
endmodule
`default_nettype wire

### verif/tb.sv
// Testbench for the sliding edge window bipartite check: queue-driven stimulus, self-checking.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sewb_pkg::*;

    typedef struct packed {
        logic       req_type;
        logic [9:0] node_a;
        logic [9:0] node_b;
    } t_req;

    typedef struct packed {
        logic        bipartite;
        logic [1:0]  status;
        logic [10:0] edge_count;
    } t_res;

    logic i_clk;
    logic i_rst_n;

    sewb_req_if req_ch ();
    sewb_res_if res_ch ();

    sliding_edge_window_bipartite_check i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_res  (res_ch.source)
    );

    // shadow union-find state
    int unsigned uf_parent [NODES];
    int unsigned uf_size   [NODES];
    bit          uf_par    [NODES];
    bit          log_valid [MAX_EDGES];
    int unsigned log_node  [MAX_EDGES];
    bit          log_par   [MAX_EDGES];
    bit          log_flag  [MAX_EDGES];
    int unsigned win_a     [MAX_EDGES];
    int unsigned win_b     [MAX_EDGES];
    bit          win_type  [MAX_EDGES];
    int unsigned win_depth;
    bit          bip_flag;

    t_req        pending_reqs[$];
    t_res        expected_res[$];
    int unsigned errors;
    int unsigned cycles;
    int unsigned stall_left;
    bit          hold_off;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned root_of(input int unsigned u, output bit p);
        int unsigned steps;
        p = 1'b0;
        steps = 0;
        while (uf_parent[u] != u && steps < NODES) begin
            p ^= uf_par[u];
            u = uf_parent[u];
            steps++;
        end
        return u;
    endfunction

    function automatic void merge_ends(input int unsigned slot, input int unsigned a,
                                       input int unsigned b);
        bit          pa, pb, z;
        int unsigned ra, rb, t;
        ra = root_of(a, pa);
        rb = root_of(b, pb);
        log_flag[slot] = bip_flag;
        z = pa ^ pb ^ 1'b1;
        if (ra == rb) begin
            if (z) bip_flag = 1'b0;
            log_valid[slot] = 1'b0;
            log_node[slot]  = 0;
            log_par[slot]   = 1'b0;
        end else begin
            if (uf_size[ra] > uf_size[rb]) begin
                t = ra; ra = rb; rb = t;
            end
            log_valid[slot] = 1'b1;
            log_node[slot]  = ra;
            log_par[slot]   = uf_par[ra];
            uf_parent[ra]   = rb;
            uf_par[ra]      = z;
            uf_size[rb]    += uf_size[ra];
        end
    endfunction

    function automatic void rollback(input int unsigned slot);
        int unsigned u;
        bip_flag = log_flag[slot];
        if (log_valid[slot]) begin
            u = log_node[slot];
            uf_size[uf_parent[u]] -= uf_size[u];
            uf_parent[u] = u;
            uf_par[u]    = log_par[slot];
        end
    endfunction

    function automatic void stack_edge(input int unsigned a, input int unsigned b,
                                       input bit et);
        merge_ends(win_depth, a, b);
        win_a[win_depth]    = a;
        win_b[win_depth]    = b;
        win_type[win_depth] = et;
        win_depth++;
    endfunction

    function automatic void drop_oldest();
        int unsigned l0a[$], l0b[$], l1a[$], l1b[$];
        int i;
        do begin
            win_depth--;
            if (win_type[win_depth]) begin
                l1a = {l1a, win_a[win_depth]};
                l1b = {l1b, win_b[win_depth]};
            end else begin
                l0a = {l0a, win_a[win_depth]};
                l0b = {l0b, win_b[win_depth]};
            end
            rollback(win_depth);
        end while (l1a.size() < l0a.size() && win_depth > 0);
        if (l1a.size() == 0) begin
            for (i = 0; i < l0a.size(); i++) stack_edge(l0a[i], l0b[i], 1'b1);
        end else begin
            for (i = l0a.size() - 1; i >= 0; i--) stack_edge(l0a[i], l0b[i], 1'b0);
            for (i = l1a.size() - 1; i >= 0; i--) stack_edge(l1a[i], l1b[i], 1'b1);
        end
        win_depth--;
        rollback(win_depth);
    endfunction

    function automatic t_res predict_window(input t_req r);
        t_res res;
        res.status = ST_DONE;
        if (r.req_type) begin
            if (win_depth == 0) res.status = ST_EMPTY;
            else drop_oldest();
        end else begin
            if (win_depth >= MAX_EDGES) res.status = ST_FULL;
            else stack_edge(r.node_a, r.node_b, 1'b0);
        end
        res.bipartite  = bip_flag;
        res.edge_count = win_depth[10:0];
        return res;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_req mk_req(input bit op, input int unsigned a, input int unsigned b);
        t_req r;
        r.req_type = op;
        r.node_a   = a[9:0];
        r.node_b   = b[9:0];
        return r;
    endfunction

    function automatic void add_req(input t_req r);
        pending_reqs = {pending_reqs, r};
    endfunction

    // driver
    int unsigned send_gap;
    bit          req_taken;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && !req_taken) begin
        end else if (send_gap != 0) begin
            send_gap     <= send_gap - 1;
            req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
            t_req r;
            t_res e;
            r = pending_reqs.pop_front();
            e = predict_window(r);
            expected_res = {expected_res, e};
            req_ch.valid    <= 1'b1;
            req_ch.req_type <= r.req_type;
            req_ch.node_a   <= r.node_a;
            req_ch.node_b   <= r.node_b;
            send_gap        <= gap_len();
        end else begin
            req_ch.valid <= 1'b0;
        end
    end

    // receiver ready
    always @(negedge i_clk) begin
        if (hold_off) begin
            res_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= gap_len();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles    <= cycles + 1;
        req_taken <= i_rst_n && req_ch.valid && req_ch.ready;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            t_res got, want;
            bit   bad;
            got = '{res_ch.bipartite, res_ch.status, res_ch.edge_count};
            bad = 1'b0;
            if (expected_res.size() == 0) begin
                bad = 1'b1;
                $display("%0t: unexpected transfer %p", $time, got);
            end else begin
                want = expected_res.pop_front();
                if (got.bipartite !== want.bipartite) begin
                    bad = 1'b1;
                    $display("%0t: bipartite exp %0b got %0b", $time, want.bipartite,
                             got.bipartite);
                end
                if (got.status !== want.status) begin
                    bad = 1'b1;
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                end
                if (got.edge_count !== want.edge_count) begin
                    bad = 1'b1;
                    $display("%0t: edge_count exp %0d got %0d", $time, want.edge_count,
                             got.edge_count);
                end
            end
            if (bad) errors <= errors + 1;
        end
        if (cycles > 6000000) begin
            $display("FAIL sliding_edge_window_bipartite_check");
            $finish;
        end
    end

    initial begin
        int unsigned i, n, base;
        for (i = 0; i < NODES; i++) begin
            uf_parent[i] = i; uf_size[i] = 1; uf_par[i] = 1'b0;
        end
        win_depth = 0; bip_flag = 1'b1;
        errors = 0; cycles = 0; stall_left = 0; hold_off = 1'b0; send_gap = 0;
        req_ch.valid = 1'b0; req_ch.req_type = 1'b0;
        req_ch.node_a = '0; req_ch.node_b = '0;
        res_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pop, extremes, self loop, odd cycle, pops
        add_req(mk_req(1, 0, 0));
        add_req(mk_req(0, 0, 1023));
        add_req(mk_req(0, 1023, 1));
        add_req(mk_req(0, 1, 0));
        add_req(mk_req(0, 5, 5));
        add_req(mk_req(1, 1023, 1023));
        add_req(mk_req(0, 682, 341));
        add_req(mk_req(1, 0, 0));
        add_req(mk_req(1, 0, 0));
        add_req(mk_req(1, 0, 0));
        add_req(mk_req(1, 0, 0));
        add_req(mk_req(1, 0, 0));
        // fill the window past full, holding result ready low part way through
        for (i = 0; i < MAX_EDGES + 2; i++)
            add_req(mk_req(0, $urandom_range(0, 1023), $urandom_range(0, 1023)));
        wait (pending_reqs.size() < 900);
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
        // random: sliding windows over small node sets so cycles form and break
        n = 0;
        while (n < 110) begin
            wait (pending_reqs.size() < 16);
            base = $urandom_range(0, 1023);
            if ($urandom_range(0, 9) < 6)
                add_req(mk_req(1, $urandom, $urandom));
            else if ($urandom_range(0, 9) == 0)
                add_req(mk_req(0, $urandom, $urandom));
            else
                add_req(mk_req(0, (base + $urandom_range(0, 7)) % 1024,
                               (base + $urandom_range(0, 7)) % 1024));
            n++;
        end
        wait (pending_reqs.size() == 0 && expected_res.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("PASS sliding_edge_window_bipartite_check");
        else
            $display("FAIL sliding_edge_window_bipartite_check");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
rtl/sewb_pkg.sv
rtl/sewb_if.sv
rtl/sewb_ctrl.sv
rtl/sewb_dp.sv
rtl/sliding_edge_window_bipartite_check.sv
verif/tb.sv
